// ----- sv/asd_pkg.sv -----
// Shared constants and types of the accelerometer step detector.
package asd_pkg;

    localparam int MAG_W      = 16;
    localparam int COUNT_W    = 16;
    localparam int COOL_W     = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_RISE_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FALL_THRESHOLD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN_LENGTH = 2'd2;

    // Reset values of the configuration registers (0.3 in Q12 for thresholds).
    localparam logic [CFG_DATA_W-1:0] RISE_RESET = 16'd1229;
    localparam logic [CFG_DATA_W-1:0] FALL_RESET = 16'd1229;
    localparam logic [COOL_W-1:0]     COOL_RESET = 4'd8;

    localparam logic [COUNT_W-1:0] COUNT_ONE = 16'd1;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'b001,
        ST_BUSY    = 3'b010,
        ST_DELIVER = 3'b100
    } t_state;

    typedef enum logic [2:0] {
        MS_IDLE   = 3'b001,
        MS_SQUARE = 3'b010,
        MS_ROOT   = 3'b100
    } t_mag_state;

endpackage

// ----- sv/asd_in_if.sv -----
// Input channel of the step detector: one accelerometer sample per beat.
interface asd_in_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] acc_x;
    logic signed [SAMPLE_WIDTH-1:0] acc_y;
    logic signed [SAMPLE_WIDTH-1:0] acc_z;

    modport source (output valid, output acc_x, output acc_y, output acc_z, input ready);
    modport sink   (input valid, input acc_x, input acc_y, input acc_z, output ready);
endinterface

// ----- sv/asd_out_if.sv -----
// Output channel of the step detector: step count, step flag and magnitude per beat.
interface asd_out_if;
    logic                          valid;
    logic                          ready;
    logic [asd_pkg::COUNT_W-1:0]   steps_total;
    logic                          step_seen;
    logic [asd_pkg::MAG_W-1:0]     magnitude;

    modport source (output valid, output steps_total, output step_seen, output magnitude,
                    input ready);
    modport sink   (input valid, input steps_total, input step_seen, input magnitude,
                    output ready);
endinterface

// ----- sv/asd_mag_unit.sv -----
// Iterative magnitude unit: sum of squares on one multiplier, then a bit-serial square root.
module asd_mag_unit #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic signed [SAMPLE_WIDTH-1:0] i_acc_x,
    input  logic signed [SAMPLE_WIDTH-1:0] i_acc_y,
    input  logic signed [SAMPLE_WIDTH-1:0] i_acc_z,
    output logic                           o_done,
    output logic [asd_pkg::MAG_W-1:0]      o_magnitude
);

    localparam int SQ_W  = 2 * SAMPLE_WIDTH;
    localparam int REM_W = SAMPLE_WIDTH + 2;
    localparam int CNT_W = $clog2(SAMPLE_WIDTH);
    localparam int MAG_W = asd_pkg::MAG_W;
    localparam logic [CNT_W-1:0] SQUARE_LAST = CNT_W'(3);
    localparam logic [CNT_W-1:0] ROOT_LAST   = CNT_W'(SAMPLE_WIDTH - 1);

    function automatic logic [SAMPLE_WIDTH-1:0] f_abs(input logic [SAMPLE_WIDTH-1:0] v);
        return v[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(~v + 1'b1) : v;
    endfunction

    asd_pkg::t_mag_state r_state;
    logic                    r_done;
    logic [CNT_W-1:0]        r_cnt;
    logic [SAMPLE_WIDTH-1:0] r_op0;
    logic [SAMPLE_WIDTH-1:0] r_op1;
    logic [SAMPLE_WIDTH-1:0] r_op2;
    logic [SQ_W-1:0]         r_prod;
    logic [SQ_W-1:0]         r_rad;
    logic [REM_W-1:0]        r_rem;
    logic [SAMPLE_WIDTH-1:0] r_root;

    logic [REM_W-1:0]        w_rem_sh;
    logic [REM_W-1:0]        w_trial;
    logic                    w_fit;
    logic [REM_W-1:0]        n_rem;
    logic [SAMPLE_WIDTH-1:0] n_root;

    // One root bit per cycle: bring down the next two radicand bits and try 4*root+1.
    always_comb begin
        w_rem_sh = {r_rem[SAMPLE_WIDTH-1:0], r_rad[SQ_W-1 -: 2]};
        w_trial  = {r_root, 2'b01};
        w_fit    = (w_rem_sh >= w_trial);
        n_rem    = w_fit ? (w_rem_sh - w_trial) : w_rem_sh;
        n_root   = {r_root[SAMPLE_WIDTH-2:0], w_fit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= asd_pkg::MS_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                asd_pkg::MS_IDLE: begin
                    if (i_start) begin
                        r_op0   <= f_abs(i_acc_x);
                        r_op1   <= f_abs(i_acc_y);
                        r_op2   <= f_abs(i_acc_z);
                        r_prod  <= '0;
                        r_rad   <= '0;
                        r_cnt   <= '0;
                        r_state <= asd_pkg::MS_SQUARE;
                    end
                end
                asd_pkg::MS_SQUARE: begin
                    // The accumulate adds each product in the cycle after its multiply.
                    r_prod <= SQ_W'(r_op0) * SQ_W'(r_op0);
                    r_op0  <= r_op1;
                    r_op1  <= r_op2;
                    r_rad  <= r_rad + r_prod;
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == SQUARE_LAST) begin
                        r_cnt   <= '0;
                        r_rem   <= '0;
                        r_root  <= '0;
                        r_state <= asd_pkg::MS_ROOT;
                    end
                end
                asd_pkg::MS_ROOT: begin
                    r_rad  <= r_rad << 2;
                    r_rem  <= n_rem;
                    r_root <= n_root;
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == ROOT_LAST) begin
                        r_cnt   <= '0;
                        r_done  <= 1'b1;
                        r_state <= asd_pkg::MS_IDLE;
                    end
                end
                default: begin
                    r_state <= asd_pkg::MS_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;

    // Wide samples can give a root above the output range; it saturates.
    generate
        if (SAMPLE_WIDTH > MAG_W) begin : g_sat
            assign o_magnitude = (|r_root[SAMPLE_WIDTH-1:MAG_W]) ? '1 : r_root[MAG_W-1:0];
        end else begin : g_ext
            assign o_magnitude = MAG_W'(r_root);
        end
    endgenerate

endmodule

// ----- sv/accel_step_detector_core.sv -----
// Top level of the accelerometer step detector: sequencing, step detection and ports.
//
// Each accepted sample (three signed Q12 axes) yields exactly one output beat holding the
// running step count, a flag for a step completed by this sample, and the Q12 magnitude
// floor(sqrt(x*x + y*y + z*z)), saturated at 65535. A sample occupies the block through an
// accept cycle, the squaring of its three axes on the shared multiplier, one square-root bit
// per cycle, a done cycle and a detection cycle that loads the output register. The input is
// not ready during that time; a finished beat waits in the output register while the next
// sample is taken, and the detection cycle holds until that register is free. Configuration
// writes are expected only while the block is idle; a write to an unused index is ignored.
module accel_step_detector_core #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    asd_in_if.sink                            i_in,
    asd_out_if.source                         o_out,
    input  logic                              i_cfg_we,
    input  logic [asd_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [asd_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    asd_pkg::t_state r_state;

    logic [asd_pkg::CFG_DATA_W-1:0] r_rise;
    logic [asd_pkg::CFG_DATA_W-1:0] r_fall;
    logic [asd_pkg::COOL_W-1:0]     r_cool_len;

    logic [asd_pkg::MAG_W-1:0]      r_prev;
    logic                           r_armed;
    logic [asd_pkg::COOL_W-1:0]     r_cool;
    logic [asd_pkg::COUNT_W-1:0]    r_steps;
    logic [asd_pkg::MAG_W-1:0]      r_mag;

    logic                           r_out_valid;
    logic [asd_pkg::COUNT_W-1:0]    r_out_steps;
    logic                           r_out_seen;
    logic [asd_pkg::MAG_W-1:0]      r_out_mag;

    logic                           w_accept;
    logic                           w_mag_done;
    logic [asd_pkg::MAG_W-1:0]      w_magnitude;
    logic                           w_rise;
    logic                           w_fall;
    logic                           w_cool_busy;
    logic                           w_step;
    logic                           w_load;
    logic [asd_pkg::COUNT_W-1:0]    n_steps;

    assign i_in.ready = (r_state == asd_pkg::ST_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;

    asd_mag_unit #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_mag (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_accept),
        .i_acc_x     (i_in.acc_x),
        .i_acc_y     (i_in.acc_y),
        .i_acc_z     (i_in.acc_z),
        .o_done      (w_mag_done),
        .o_magnitude (w_magnitude)
    );

    // Thresholds are compared against the unsigned rise or fall, taken only in its direction.
    always_comb begin
        w_rise      = (r_mag > r_prev) && ((r_mag - r_prev) > r_rise);
        w_fall      = (r_prev > r_mag) && ((r_prev - r_mag) > r_fall);
        w_cool_busy = (r_cool != '0);
        w_step      = !w_cool_busy && r_armed && w_fall;
        w_load      = (r_state == asd_pkg::ST_DELIVER) && (!r_out_valid || o_out.ready);
        n_steps     = r_steps + asd_pkg::COUNT_ONE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= asd_pkg::ST_IDLE;
            r_rise      <= asd_pkg::RISE_RESET;
            r_fall      <= asd_pkg::FALL_RESET;
            r_cool_len  <= asd_pkg::COOL_RESET;
            r_prev      <= '0;
            r_armed     <= 1'b0;
            r_cool      <= '0;
            r_steps     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    asd_pkg::CFG_RISE_THRESHOLD:  r_rise     <= i_cfg_data;
                    asd_pkg::CFG_FALL_THRESHOLD:  r_fall     <= i_cfg_data;
                    asd_pkg::CFG_COOLDOWN_LENGTH: r_cool_len <= i_cfg_data[asd_pkg::COOL_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                asd_pkg::ST_IDLE: begin
                    if (w_accept) begin
                        r_state <= asd_pkg::ST_BUSY;
                    end
                end
                asd_pkg::ST_BUSY: begin
                    if (w_mag_done) begin
                        r_mag   <= w_magnitude;
                        r_state <= asd_pkg::ST_DELIVER;
                    end
                end
                asd_pkg::ST_DELIVER: begin
                    if (w_load) begin
                        r_prev      <= r_mag;
                        r_out_mag   <= r_mag;
                        r_out_seen  <= w_step;
                        r_out_steps <= w_step ? n_steps : r_steps;
                        if (w_cool_busy) begin
                            r_cool <= r_cool - 1'b1;
                        end else if (!r_armed && w_rise) begin
                            r_armed <= 1'b1;
                        end else if (w_step) begin
                            r_armed <= 1'b0;
                            r_steps <= n_steps;
                            r_cool  <= r_cool_len;
                        end
                        r_state <= asd_pkg::ST_IDLE;
                    end
                end
                default: begin
                    r_state <= asd_pkg::ST_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.steps_total = r_out_steps;
    assign o_out.step_seen   = r_out_seen;
    assign o_out.magnitude   = r_out_mag;

    a_accept_starts_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == asd_pkg::ST_BUSY))
        else $error("accepted sample did not start the magnitude unit");

    a_done_only_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mag_done |-> (r_state == asd_pkg::ST_BUSY))
        else $error("magnitude result arrived with no sample in flight");

    a_step_counts_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_step) |=> ((r_steps - $past(r_steps)) == asd_pkg::COUNT_ONE))
        else $error("a completed step did not advance the count by one");

    a_step_reloads_cooldown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_step) |=> (r_cool == $past(r_cool_len) && !r_armed && r_out_seen))
        else $error("a completed step did not reload the cooldown");

endmodule

// ----- bench/testbench.sv -----
// Self-checking testbench for the accelerometer step detector core.
`timescale 1ns / 1ps

module testbench;

    localparam int  SAMPLE_W        = 16;
    localparam int  IDLE_LIMIT      = 4000;
    localparam int  HOLD_OFF_CYCLES = 300;
    localparam int  ITEMS_PER_PHASE = 375;
    localparam int  ZERO_COOL_ROW   = 11;
    localparam int  DRAIN_CYCLES    = 40;
    localparam logic [asd_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [asd_pkg::COUNT_W-1:0] steps;
        logic                        seen;
        logic [asd_pkg::MAG_W-1:0]   mag;
    } t_step_result;

    typedef struct packed {
        logic [SAMPLE_W-1:0] x;
        logic [SAMPLE_W-1:0] y;
        logic [SAMPLE_W-1:0] z;
        bit                  typed;
        t_step_result        res;
    } t_dir_row;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [asd_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [asd_pkg::CFG_DATA_W-1:0] cfg_data;

    asd_in_if #(.SAMPLE_WIDTH(SAMPLE_W)) in_ch ();
    asd_out_if                           out_ch ();

    accel_step_detector_core #(
        .SAMPLE_WIDTH (SAMPLE_W)
    ) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // Predictor state and its copy of the configuration.
    logic [asd_pkg::CFG_DATA_W-1:0] rise_thr;
    logic [asd_pkg::CFG_DATA_W-1:0] fall_thr;
    logic [asd_pkg::COOL_W-1:0]     cool_len;
    logic [asd_pkg::MAG_W-1:0]      last_mag;
    logic                           armed;
    logic [asd_pkg::COOL_W-1:0]     cool_left;
    logic [asd_pkg::COUNT_W-1:0]    pred_steps;

    t_step_result expected_q[$];
    t_dir_row     dir_rows[$];

    int  error_count;
    int  samples_sent;
    int  beats_checked;
    int  steps_observed;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_pending;
    bit  gait_high;

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        $display("mismatch: %s, got %0d, expected %0d, at %0t", what, got, want, $time);
    endtask

    function automatic t_step_result predict_step_result(input logic signed [SAMPLE_W-1:0] ax,
                                                         input logic signed [SAMPLE_W-1:0] ay,
                                                         input logic signed [SAMPLE_W-1:0] az);
        longint                    sum_sq;
        longint                    root;
        longint                    trial;
        logic [asd_pkg::MAG_W-1:0] mag;
        int                        delta;
        t_step_result              r;
        sum_sq = longint'(ax) * longint'(ax) + longint'(ay) * longint'(ay)
               + longint'(az) * longint'(az);
        // Build the floor root one bit at a time from the top down.
        root = 0;
        for (int b = 17; b >= 0; b--) begin
            trial = root | (longint'(1) << b);
            if (trial * trial <= sum_sq)
                root = trial;
        end
        mag   = (root > 65535) ? 16'hFFFF : root[asd_pkg::MAG_W-1:0];
        delta = int'(mag) - int'(last_mag);
        r.seen = 1'b0;
        last_mag = mag;
        if (cool_left != 0) begin
            cool_left = cool_left - 1'b1;
        end else if (!armed && delta > int'(rise_thr)) begin
            armed = 1'b1;
        end else if (armed && delta < -int'(fall_thr)) begin
            armed = 1'b0;
            pred_steps = pred_steps + asd_pkg::COUNT_ONE;
            cool_left = cool_len;
            r.seen = 1'b1;
        end
        r.steps = pred_steps;
        r.mag   = mag;
        return r;
    endfunction

    // Offers one sample, holds it until accepted, then queues its expected beat.
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] x,
                               input logic signed [SAMPLE_W-1:0] y,
                               input logic signed [SAMPLE_W-1:0] z,
                               input bit use_typed, input t_step_result typed_res);
        t_step_result pred;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid = 1'b1;
        in_ch.acc_x = x;
        in_ch.acc_y = y;
        in_ch.acc_z = z;
        do @(posedge clk); while (!in_ch.ready);
        pred = predict_step_result(x, y, z);
        expected_q.push_back(use_typed ? typed_res : pred);
        samples_sent++;
    endtask

    // Registers change only with the block empty.
    task automatic write_reg(input logic [asd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [asd_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (expected_q.size() != 0)
            @(negedge clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = data;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            asd_pkg::CFG_RISE_THRESHOLD:  rise_thr = data;
            asd_pkg::CFG_FALL_THRESHOLD:  fall_thr = data;
            asd_pkg::CFG_COOLDOWN_LENGTH: cool_len = data[asd_pkg::COOL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic add_row(input logic [SAMPLE_W-1:0] x, input logic [SAMPLE_W-1:0] y,
                           input logic [SAMPLE_W-1:0] z, input bit typed,
                           input logic [asd_pkg::COUNT_W-1:0] steps, input logic seen,
                           input logic [asd_pkg::MAG_W-1:0] mag);
        t_dir_row row;
        row.x         = x;
        row.y         = y;
        row.z         = z;
        row.typed     = typed;
        row.res.steps = steps;
        row.res.seen  = seen;
        row.res.mag   = mag;
        dir_rows.push_back(row);
    endtask

    // Receiver: random stalls, plus one long hold-off counted here.
    initial begin : receiver
        int hold_left;
        hold_left    = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_pending) begin
                hold_left    = HOLD_OFF_CYCLES;
                hold_pending = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready = 1'b0;
            end else begin
                out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge clk) begin : beat_check
        t_step_result want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("beat with nothing expected, magnitude", out_ch.magnitude, -1);
            end else begin
                want = expected_q.pop_front();
                beats_checked++;
                if (out_ch.step_seen)
                    steps_observed++;
                if (out_ch.steps_total !== want.steps)
                    report_mismatch("steps_total", out_ch.steps_total, want.steps);
                if (out_ch.step_seen !== want.seen)
                    report_mismatch("step_seen", out_ch.step_seen, want.seen);
                if (out_ch.magnitude !== want.mag)
                    report_mismatch("magnitude", out_ch.magnitude, want.mag);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("testbench: done, errors");
        $finish;
    end

    initial begin : main
        logic signed [SAMPLE_W-1:0] sx;
        logic signed [SAMPLE_W-1:0] sy;
        logic signed [SAMPLE_W-1:0] sz;
        int                         level;
        t_step_result               none;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_idx        = asd_pkg::CFG_RISE_THRESHOLD;
        cfg_data       = '0;
        in_ch.valid    = 1'b0;
        in_ch.acc_x    = '0;
        in_ch.acc_y    = '0;
        in_ch.acc_z    = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_pending   = 1'b0;
        gait_high      = 1'b0;
        error_count    = 0;
        samples_sent   = 0;
        beats_checked  = 0;
        steps_observed = 0;
        none           = '0;
        rise_thr       = asd_pkg::RISE_RESET;
        fall_thr       = asd_pkg::FALL_RESET;
        cool_len       = asd_pkg::COOL_RESET;
        last_mag       = '0;
        armed          = 1'b0;
        cool_left      = '0;
        pred_steps     = '0;

        // Default thresholds 1229, cooldown 8; a step then eight ignored samples.
        add_row(16'h0000, 16'h0000, 16'h0000, 1, 16'd0, 1'b0, 16'd0);
        add_row(16'h7FFF, 16'h0000, 16'h0000, 1, 16'd0, 1'b0, 16'd32767);
        add_row(16'h0000, 16'h0000, 16'h0000, 1, 16'd1, 1'b1, 16'd0);
        add_row(16'h8000, 16'h8000, 16'h8000, 1, 16'd1, 1'b0, 16'd56755);
        add_row(16'h7FFF, 16'h7FFF, 16'h7FFF, 1, 16'd1, 1'b0, 16'd56754);
        add_row(16'h0000, 16'h8000, 16'h0000, 1, 16'd1, 1'b0, 16'd32768);
        add_row(16'h0000, 16'h0000, 16'hFFFF, 1, 16'd1, 1'b0, 16'd1);
        add_row(16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 16'd1, 1'b0, 16'd1);
        add_row(16'h0003, 16'h0004, 16'h0000, 1, 16'd1, 1'b0, 16'd5);
        add_row(16'h0000, 16'h0000, 16'h1000, 1, 16'd1, 1'b0, 16'd4096);
        add_row(16'h0000, 16'h0000, 16'h1000, 1, 16'd1, 1'b0, 16'd4096);
        // Thresholds hit exactly and by one, rise while armed, then zero cooldown.
        add_row(16'h0000, 16'h0000, 16'd5325, 1, 16'd1, 1'b0, 16'd5325);
        add_row(16'h0000, 16'h0000, 16'd6555, 1, 16'd1, 1'b0, 16'd6555);
        add_row(16'h0000, 16'h0000, 16'd8190, 1, 16'd1, 1'b0, 16'd8190);
        add_row(16'h0000, 16'h0000, 16'd6961, 1, 16'd1, 1'b0, 16'd6961);
        add_row(16'h0000, 16'h0000, 16'd5731, 1, 16'd2, 1'b1, 16'd5731);
        add_row(16'h0000, 16'h0000, 16'd8192, 1, 16'd2, 1'b0, 16'd8192);
        add_row(16'h0000, 16'h0000, 16'd4096, 1, 16'd3, 1'b1, 16'd4096);
        add_row(16'h5555, 16'hAAAA, 16'h7FFF, 0, 16'd0, 1'b0, 16'd0);
        add_row(16'hAAAA, 16'h5555, 16'h8000, 0, 16'd0, 1'b0, 16'd0);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int r = 0; r < dir_rows.size(); r++) begin
            if (r == ZERO_COOL_ROW) begin
                // The unused index must leave every register alone.
                write_reg(CFG_UNUSED, 16'h0000);
                write_reg(asd_pkg::CFG_COOLDOWN_LENGTH, 16'd0);
            end
            send_sample(dir_rows[r].x, dir_rows[r].y, dir_rows[r].z,
                        dir_rows[r].typed, dir_rows[r].res);
        end

        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
            case (p)
                0: begin
                    write_reg(asd_pkg::CFG_RISE_THRESHOLD, 16'd0);
                    write_reg(asd_pkg::CFG_FALL_THRESHOLD, 16'd0);
                    write_reg(asd_pkg::CFG_COOLDOWN_LENGTH, 16'd0);
                end
                1: begin
                    write_reg(asd_pkg::CFG_RISE_THRESHOLD, 16'hFFFF);
                    write_reg(asd_pkg::CFG_FALL_THRESHOLD, 16'hFFFF);
                    write_reg(asd_pkg::CFG_COOLDOWN_LENGTH, 16'd15);
                    send_idle_pct = 86;
                end
                2: begin
                    write_reg(asd_pkg::CFG_RISE_THRESHOLD, 16'($urandom_range(4000, 200)));
                    write_reg(asd_pkg::CFG_FALL_THRESHOLD, 16'($urandom_range(4000, 200)));
                    write_reg(asd_pkg::CFG_COOLDOWN_LENGTH, 16'($urandom_range(15, 0)));
                    write_reg(CFG_UNUSED, 16'($urandom));
                    recv_stall_pct = 86;
                end
                default: begin
                    write_reg(asd_pkg::CFG_RISE_THRESHOLD, 16'($urandom_range(2500, 0)));
                    write_reg(asd_pkg::CFG_FALL_THRESHOLD, 16'($urandom_range(2500, 0)));
                    write_reg(asd_pkg::CFG_COOLDOWN_LENGTH, 16'($urandom_range(3, 0)));
                    send_idle_pct  = 18;
                    recv_stall_pct = 18;
                end
            endcase
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                if (p == 0 && i == 20)
                    hold_pending = 1'b1;
                if ($urandom_range(99) < 25) begin
                    sx = 16'($urandom);
                    sy = 16'($urandom);
                    sz = 16'($urandom);
                end else begin
                    // Walking gait: the vertical axis swings between a low and a high
                    // level, now and then staying put.
                    if ($urandom_range(9) != 0)
                        gait_high = !gait_high;
                    level = gait_high ? int'($urandom_range(9000, 5500))
                                      : int'($urandom_range(4500, 1500));
                    sx = 16'(int'($urandom_range(1600, 0)) - 800);
                    sy = 16'(int'($urandom_range(1600, 0)) - 800);
                    sz = $urandom_range(1, 0) ? 16'(-level) : 16'(level);
                end
                send_sample(sx, sy, sz, 1'b0, none);
            end
        end

        @(negedge clk);
        in_ch.valid = 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("summary: %0d samples sent, %0d beats checked, %0d steps flagged",
                 samples_sent, beats_checked, steps_observed);
        $display("summary: idling none, sender, receiver and both; long receiver hold-off; "
                 , "threshold and cooldown extremes");
        if (error_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
